@@ design/saslsw_pkg.sv @@
`timescale 1ns / 1ps

package saslsw_pkg;

    localparam logic [31:0] FULL_SCALE = 32'h8000_0000;

    localparam logic [1:0] FMT_FLOAT32 = 2'd0;
    localparam logic [1:0] FMT_INT16   = 2'd1;
    localparam logic [1:0] FMT_INT32   = 2'd2;

    localparam logic [2:0] REG_AUTO_ENABLE   = 3'd0;
    localparam logic [2:0] REG_SAMPLE_FORMAT = 3'd1;
    localparam logic [2:0] REG_MONITOR_MASK  = 3'd2;
    localparam logic [2:0] REG_THRESHOLD     = 3'd3;
    localparam logic [2:0] REG_HOLD_PACKETS  = 3'd4;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // classified sample word handed from front to back
    typedef struct packed {
        logic [31:0] mag;
        logic        last;
        logic        is_real;
    } saslsw_item_t;

    typedef struct packed {
        logic        surround_selected;
        logic        activity_seen;
        logic [31:0] peak_level;
    } saslsw_result_t;

    typedef struct packed {
        logic        auto_enable;
        logic        mask_any;
        logic [31:0] threshold;
        logic [15:0] hold_packets;
    } saslsw_back_cfg_t;

endpackage

@@ design/saslsw_queue.sv @@
`timescale 1ns / 1ps

module saslsw_queue
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ design/saslsw_front.sv @@
`timescale 1ns / 1ps

module saslsw_front
    import saslsw_pkg::*;
(
    input  logic [31:0]  sample,
    input  logic [1:0]   sample_format,
    input  logic         monitored,
    input  logic         last_of_packet,
    input  logic         real_input,
    output saslsw_item_t item
);

    logic [7:0]  exp_f;
    logic [23:0] sig_f;
    logic [2:0]  shl_f;
    logic [7:0]  shr_f;
    logic [31:0] mag_float;
    logic [15:0] mag16;
    logic [31:0] mag;

    always_comb
    begin
        exp_f = sample[30:23];
        sig_f = {1'b1, sample[22:0]};
        shl_f = 3'(exp_f - 8'd119);
        shr_f = 8'd119 - exp_f;
        // |x| * 2^31 truncated; zero/subnormal and inf/nan read as silence
        if (exp_f == 8'hFF || exp_f == 8'h00)
        begin
            mag_float = '0;
        end
        else if (exp_f >= 8'd127)
        begin
            mag_float = FULL_SCALE;
        end
        else if (exp_f >= 8'd119)
        begin
            mag_float = {8'd0, sig_f} << shl_f;
        end
        else if (shr_f >= 8'd24)
        begin
            mag_float = '0;
        end
        else
        begin
            mag_float = {8'd0, sig_f >> shr_f[4:0]};
        end

        // -32768 wraps to 0x8000 which is already full scale
        mag16 = sample[15] ? (16'd0 - sample[15:0]) : sample[15:0];

        case (sample_format)
            FMT_FLOAT32: mag = mag_float;
            FMT_INT16:   mag = {mag16, 16'd0};
            FMT_INT32:   mag = sample[31] ? (32'd0 - sample) : sample;
            default:     mag = '0;
        endcase

        item.mag     = monitored ? mag : '0;
        item.last    = last_of_packet;
        item.is_real = real_input;
    end

endmodule

@@ design/saslsw_back.sv @@
`timescale 1ns / 1ps

module saslsw_back
    import saslsw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  saslsw_back_cfg_t cfg,
    input  logic             item_valid,
    input  saslsw_item_t     item,
    output logic             res_valid,
    output saslsw_result_t   res
);

    logic [31:0] peak_reg;
    logic [31:0] peak_next;
    logic [15:0] quiet_reg;
    logic [15:0] quiet_next;
    logic        surround_reg;
    logic        surround_next;
    logic [31:0] peak_cur;
    logic [15:0] quiet_inc;
    logic        active;

    always_comb
    begin
        peak_cur      = (item.mag > peak_reg) ? item.mag : peak_reg;
        quiet_inc     = quiet_reg + 16'd1;
        active        = cfg.mask_any && (peak_cur >= cfg.threshold);
        peak_next     = peak_reg;
        quiet_next    = quiet_reg;
        surround_next = surround_reg;
        res_valid     = item_valid && item.last;
        res           = '0;

        if (item_valid)
        begin
            peak_next = item.last ? '0 : peak_cur;
        end

        if (item_valid && item.last && item.is_real && cfg.auto_enable)
        begin
            if (active)
            begin
                quiet_next    = '0;
                surround_next = 1'b1;
            end
            else if (surround_reg)
            begin
                if (quiet_inc >= cfg.hold_packets)
                begin
                    surround_next = 1'b0;
                    quiet_next    = '0;
                end
                else
                begin
                    quiet_next = quiet_inc;
                end
            end
        end

        // underrun packet end: report zero peak and no activity, keep the surround decision
        res.surround_selected = cfg.auto_enable ? surround_next : 1'b1;
        res.activity_seen     = item.is_real && active;
        res.peak_level        = item.is_real ? peak_cur : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg     <= '0;
            quiet_reg    <= '0;
            surround_reg <= 1'b0;
        end
        else
        begin
            peak_reg     <= peak_next;
            quiet_reg    <= quiet_next;
            surround_reg <= surround_next;
        end
    end

endmodule

@@ design/surround_activity_layout_switch_core.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// input     in         push / full                sample, channel, last_of_packet, real_input
// result    out        empty / pop                surround_selected, activity_seen, peak_level
// config    in         psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// One input word per cycle sustained while the result queue has room; the last word of a
// packet passes front classify, the 4-entry queue and back peak/decision, and its result is
// registered in the 2-entry result queue. full rises only when the back stalls on a full one.
// rst_n is asynchronous; it empties both queues and restores register defaults.
// Registers sit at byte address 4*i; writes complete in the access cycle, pready tied high.

module surround_activity_layout_switch_core
    import saslsw_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        push,
    output logic        full,
    input  logic [31:0] sample,
    input  logic [2:0]  channel,
    input  logic        last_of_packet,
    input  logic        real_input,

    output logic        empty,
    input  logic        pop,
    output logic        surround_selected,
    output logic        activity_seen,
    output logic [31:0] peak_level
);

    localparam int ItemW = $bits(saslsw_item_t);
    localparam int ResW  = $bits(saslsw_result_t);

    logic        auto_enable_reg;
    logic [1:0]  sample_format_reg;
    logic [7:0]  monitor_mask_reg;
    logic [31:0] threshold_reg;
    logic [15:0] hold_packets_reg;
    logic        cfg_write;
    logic [2:0]  reg_index;

    logic             chan_ok;
    logic             monitored;
    saslsw_item_t     front_item;
    logic [ItemW-1:0] mid_rdata;
    saslsw_item_t     mid_item;
    logic             mid_empty;
    logic             mid_pop;
    logic             out_full;
    saslsw_back_cfg_t back_cfg;
    logic             res_valid;
    saslsw_result_t   res;
    logic [ResW-1:0]  out_rdata;
    saslsw_result_t   out_res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_enable_reg   <= 1'b0;
            sample_format_reg <= FMT_INT16;
            monitor_mask_reg  <= '0;
            threshold_reg     <= FULL_SCALE;
            hold_packets_reg  <= 16'd1;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_AUTO_ENABLE:   auto_enable_reg   <= pwdata[0];
                REG_SAMPLE_FORMAT: sample_format_reg <= pwdata[1:0];
                REG_MONITOR_MASK:  monitor_mask_reg  <= pwdata[7:0];
                REG_THRESHOLD:     threshold_reg     <= pwdata;
                REG_HOLD_PACKETS:  hold_packets_reg  <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_AUTO_ENABLE:   prdata = {31'd0, auto_enable_reg};
            REG_SAMPLE_FORMAT: prdata = {30'd0, sample_format_reg};
            REG_MONITOR_MASK:  prdata = {24'd0, monitor_mask_reg};
            REG_THRESHOLD:     prdata = threshold_reg;
            REG_HOLD_PACKETS:  prdata = {16'd0, hold_packets_reg};
            default:           prdata = '0;
        endcase
    end

    assign chan_ok   = (32'(channel) < 32'(MAX_CHANNELS));
    assign monitored = chan_ok && monitor_mask_reg[channel] && real_input;

    saslsw_front u_front (
        .sample         (sample),
        .sample_format  (sample_format_reg),
        .monitored      (monitored),
        .last_of_packet (last_of_packet),
        .real_input     (real_input),
        .item           (front_item)
    );

    saslsw_queue #(
        .WIDTH (ItemW),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign mid_item = saslsw_item_t'(mid_rdata);
    // back waits on a full result queue even for mid-packet words
    assign mid_pop  = !mid_empty && !out_full;

    always_comb
    begin
        back_cfg.auto_enable  = auto_enable_reg;
        back_cfg.mask_any     = (monitor_mask_reg != '0);
        back_cfg.threshold    = threshold_reg;
        back_cfg.hold_packets = hold_packets_reg;
    end

    saslsw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (back_cfg),
        .item_valid (mid_pop),
        .item       (mid_item),
        .res_valid  (res_valid),
        .res        (res)
    );

    saslsw_queue #(
        .WIDTH (ResW),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata (res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign out_res           = saslsw_result_t'(out_rdata);
    assign surround_selected = out_res.surround_selected;
    assign activity_seen     = out_res.activity_seen;
    assign peak_level        = out_res.peak_level;

    a_peak_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (peak_level <= FULL_SCALE))
        else $error("peak_level above full scale");

    a_activity_selects_surround: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.activity_seen) |-> res.surround_selected)
        else $error("activity seen but stereo selected");

    a_manual_is_surround: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !auto_enable_reg) |-> res.surround_selected)
        else $error("auto off but stereo selected");

    a_underrun_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !mid_item.is_real) |-> (res.peak_level == '0 && !res.activity_seen))
        else $error("underrun packet reported activity");

endmodule
